/* hw/rtl/rllt_pkg.sv */
// Shared types, widths and codes for the run-length line table.
package rllt_pkg;

  // Fixed field widths of the item channels
  localparam int FieldLineBits = 16;
  localparam int IndexBits     = 24;

  // Defaults for the top-level parameters
  localparam int MaxRunsDefault    = 256;
  localparam int LineBitsDefault   = 16;
  localparam int RunLenBitsDefault = 16;

  typedef enum logic {
    FUNC_APPEND = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_FOUND    = 2'd1,
    ST_MISSING  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted item; appends complete here
    logic walk;  // step the lookup walk
  } rllt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;  // lookup result written to the output register
  } rllt_sts_t;

endpackage

/* hw/rtl/rllt_in_if.sv */
// Input item channel: valid/ready handshake with the request payload.
interface rllt_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    func;
  logic [rllt_pkg::FieldLineBits-1:0]      line_number;
  logic [rllt_pkg::IndexBits-1:0]          instruction_index;

  modport source (output valid, func, line_number, instruction_index, input ready);
  modport sink   (input valid, func, line_number, instruction_index, output ready);
endinterface

/* hw/rtl/rllt_out_if.sv */
// Result item channel: valid/ready handshake with the response payload.
interface rllt_out_if;
  logic                                valid;
  logic                                ready;
  logic [rllt_pkg::FieldLineBits-1:0]  found_line;
  logic [1:0]                          status;

  modport source (output valid, found_line, status, input ready);
  modport sink   (input valid, found_line, status, output ready);
endinterface

/* hw/rtl/rllt_ctrl.sv */
// Controller: sequences accept, lookup walk and result transfer.
module rllt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rllt_pkg::rllt_cmd_t cmd,
  input  rllt_pkg::rllt_sts_t sts
);
  import rllt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_OUT
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;

  assign cmd.load = accept;
  assign cmd.walk = (state == S_WALK);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_func == FUNC_LOOKUP) ? S_WALK : S_OUT;
          end
        end
        S_WALK: begin
          if (sts.walk_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/rllt_dp.sv */
// Datapath: run store, append update, lookup walk and result register.
module rllt_dp #(
  parameter int MAX_RUNS     = rllt_pkg::MaxRunsDefault,
  parameter int LINE_BITS    = rllt_pkg::LineBitsDefault,
  parameter int RUN_LEN_BITS = rllt_pkg::RunLenBitsDefault
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rllt_pkg::rllt_cmd_t                   cmd,
  output rllt_pkg::rllt_sts_t                   sts,
  input  logic                                  in_func,
  input  logic [rllt_pkg::FieldLineBits-1:0]    in_line,
  input  logic [rllt_pkg::IndexBits-1:0]        in_index,
  output logic [rllt_pkg::FieldLineBits-1:0]    res_line,
  output logic [1:0]                            res_status
);
  import rllt_pkg::*;

  localparam int AddrBits = $clog2(MAX_RUNS);
  localparam int CntBits  = $clog2(MAX_RUNS + 1);
  localparam int AccBits  = ((IndexBits > RUN_LEN_BITS) ? IndexBits : RUN_LEN_BITS) + 1;
  localparam logic [CntBits-1:0] CntFull = CntBits'(MAX_RUNS);

  // Run store
  logic [LINE_BITS-1:0]    run_line   [MAX_RUNS];
  logic [RUN_LEN_BITS-1:0] run_length [MAX_RUNS];

  // Append state: run count and a copy of the last run
  logic [CntBits-1:0]      run_total;
  logic [LINE_BITS-1:0]    last_line;
  logic [RUN_LEN_BITS-1:0] last_len;

  // Lookup walk
  logic [IndexBits-1:0]    idx;
  logic [IndexBits-1:0]    sum;
  logic [CntBits-1:0]      rd_ptr;
  logic                    rd_vld;
  logic [LINE_BITS-1:0]    rd_line;
  logic [RUN_LEN_BITS-1:0] rd_len;

  logic [LINE_BITS-1:0]    ln;
  logic                    is_append;
  logic                    grow;
  logic                    full;
  logic                    wr_en;
  logic [CntBits-1:0]      wr_slot;
  logic [AddrBits-1:0]     wr_addr;
  logic [RUN_LEN_BITS-1:0] wr_len;
  logic                    issue;
  logic [AccBits-1:0]      acc;
  logic                    hit;
  logic                    exhausted;

  assign ln        = LINE_BITS'(in_line);
  assign is_append = cmd.load && (in_func == FUNC_APPEND);
  assign grow      = (run_total != '0) && (last_line == ln) && (last_len != '1);
  assign full      = (run_total == CntFull);
  assign wr_en     = is_append && (grow || !full);
  assign wr_slot   = grow ? (run_total - CntBits'(1)) : run_total;
  assign wr_addr   = wr_slot[AddrBits-1:0];
  assign wr_len    = grow ? (last_len + RUN_LEN_BITS'(1)) : RUN_LEN_BITS'(1);

  assign issue     = cmd.walk && (rd_ptr < run_total);
  assign acc       = AccBits'(sum) + AccBits'(rd_len);
  assign hit       = cmd.walk && rd_vld && (AccBits'(idx) < acc);
  assign exhausted = cmd.walk && !rd_vld && (rd_ptr == run_total);

  assign sts.walk_done = hit || exhausted;

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      run_line[wr_addr]   <= ln;
      run_length[wr_addr] <= wr_len;
    end
    rd_line <= run_line[rd_ptr[AddrBits-1:0]];
    rd_len  <= run_length[rd_ptr[AddrBits-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_total <= '0;
      rd_vld    <= 1'b0;
    end else begin
      if (wr_en && !grow) begin
        run_total <= run_total + CntBits'(1);
      end
      if (cmd.load) begin
        rd_vld <= 1'b0;
      end else begin
        rd_vld <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_line <= ln;
      last_len  <= wr_len;
    end
    if (cmd.load) begin
      idx    <= in_index;
      sum    <= '0;
      rd_ptr <= '0;
    end else begin
      if (issue) begin
        rd_ptr <= rd_ptr + CntBits'(1);
      end
      if (cmd.walk && rd_vld) begin
        sum <= acc[IndexBits-1:0];
      end
    end
    if (is_append) begin
      res_line   <= '0;
      res_status <= wr_en ? ST_APPENDED : ST_FULL;
    end else if (hit) begin
      res_line   <= FieldLineBits'(rd_line);
      res_status <= ST_FOUND;
    end else if (exhausted) begin
      res_line   <= '0;
      res_status <= ST_MISSING;
    end
  end

endmodule

/* hw/rtl/run_length_line_table.sv */
// Top level of the run-length line table: channels, controller and datapath.
//
// Maps instruction positions to source lines as a table of runs (line,
// length). An append transfer extends the last run when its line matches and
// the run length is below its maximum, otherwise it opens a new run; with
// every run slot in use such an append is dropped and answers status 3. A
// lookup transfer walks the runs from the first, summing lengths, and answers
// the line of the run covering the index (status 1), or line zero with
// status 2 when no run covers it. The block takes one item at a time, and a
// lookup reads the runs one entry a cycle through the single read port of the
// run store. The result is held until its transfer completes, and the next
// item is taken the cycle after that. The store needs no clearing after reset.
module run_length_line_table #(
  parameter int MAX_RUNS     = rllt_pkg::MaxRunsDefault,
  parameter int LINE_BITS    = rllt_pkg::LineBitsDefault,
  parameter int RUN_LEN_BITS = rllt_pkg::RunLenBitsDefault
) (
  input logic        clk,
  input logic        rst,
  rllt_in_if.sink    req,
  rllt_out_if.source rsp
);
  import rllt_pkg::*;

  rllt_cmd_t cmd;
  rllt_sts_t sts;

  // Sequence the item: accept, walk for lookups, hold result until transfer
  rllt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_func   (req.func),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Run store, append update and lookup walk
  rllt_dp #(
    .MAX_RUNS     (MAX_RUNS),
    .LINE_BITS    (LINE_BITS),
    .RUN_LEN_BITS (RUN_LEN_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (req.func),
    .in_line    (req.line_number),
    .in_index   (req.instruction_index),
    .res_line   (rsp.found_line),
    .res_status (rsp.status)
  );

endmodule

/* bench/run_length_line_table_test.sv */
// Self-checking testbench for the run-length line table: stimulus, prediction and checking.
`timescale 1ns / 100ps

module run_length_line_table_test;
  import rllt_pkg::*;

  // The block is built with its default sizes; mirror them here.
  localparam int MaxRuns    = MaxRunsDefault;
  localparam int LineBits   = LineBitsDefault;
  localparam int RunLenBits = RunLenBitsDefault;
  localparam logic [RunLenBits-1:0] RunLenMax = '1;

  // One expected answer per accepted transfer.
  typedef struct {
    logic [FieldLineBits-1:0] line;
    status_t                  status;
  } line_answer_t;

  // Scoreboard: keeps its own copy of the run store, predicts the answer to
  // every accepted request and checks each returned answer against the oldest.
  class line_table_checker;
    logic [LineBits-1:0]   run_lines [MaxRuns];
    logic [RunLenBits-1:0] run_lens  [MaxRuns];
    int unsigned           runs_used;
    int unsigned           covered;    // sum of all run lengths
    line_answer_t          pending[$];
    int unsigned           faults;

    function new();
      runs_used = 0;
      covered   = 0;
      faults    = 0;
    endfunction

    function void flag(string what);
      faults++;
      if (faults <= 10) begin
        $display("%s", what);
      end
    endfunction

    // Update the run store for an accepted request and queue its answer.
    function void note_request(func_t f, logic [FieldLineBits-1:0] line,
                               logic [IndexBits-1:0] index);
      line_answer_t        ans;
      logic [LineBits-1:0] ln;
      longint unsigned     sum;
      ans.line   = '0;
      ans.status = ST_APPENDED;
      if (f == FUNC_APPEND) begin
        ln = line[LineBits-1:0];
        if (runs_used > 0 && run_lines[runs_used-1] == ln &&
            run_lens[runs_used-1] != RunLenMax) begin
          run_lens[runs_used-1]++;
          covered++;
        end else if (runs_used == MaxRuns) begin
          ans.status = ST_FULL;
        end else begin
          run_lines[runs_used] = ln;
          run_lens[runs_used]  = RunLenBits'(1);
          runs_used++;
          covered++;
        end
      end else begin
        sum        = 0;
        ans.status = ST_MISSING;
        for (int i = 0; i < runs_used; i++) begin
          sum += run_lens[i];
          if (index < sum) begin
            ans.line   = run_lines[i];
            ans.status = ST_FOUND;
            break;
          end
        end
      end
      pending.push_back(ans);
    endfunction

    function void check_answer(logic [FieldLineBits-1:0] line, logic [1:0] status);
      line_answer_t want;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result: line %h status %0d", line, status));
      end else begin
        want = pending.pop_front();
        if (line !== want.line || status !== want.status) begin
          flag($sformatf("mismatch: expected line %h status %0d, got line %h status %0d",
                         want.line, want.status, line, status));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady;   // when set, neither side idles

  rllt_in_if  req_ch ();
  rllt_out_if rsp_ch ();

  run_length_line_table dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  line_table_checker table_sb = new();

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Present one request, optionally after an idle gap, and hold it until the
  // transfer completes. Valid is left high so a back-to-back request needs
  // no second assignment in the same step.
  task automatic send_item(func_t f, logic [FieldLineBits-1:0] line,
                           logic [IndexBits-1:0] index);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.func              <= f;
    req_ch.line_number       <= line;
    req_ch.instruction_index <= index;
    do @(posedge clk); while (!req_ch.ready);
    table_sb.note_request(f, line, index);
  endtask

  // Favour repeats of the last line so runs grow; otherwise draw from a few
  // small lines (equal lines in separate runs), the extremes, or anything.
  function automatic logic [FieldLineBits-1:0] pick_line();
    if (table_sb.runs_used > 0 && $urandom_range(0, 99) < 65) begin
      return table_sb.run_lines[table_sb.runs_used-1];
    end
    case ($urandom_range(0, 3))
      0:       return FieldLineBits'($urandom_range(1, 4));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return FieldLineBits'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly indices within the covered span, some right at its edge, some
  // anywhere in the 24-bit range.
  function automatic logic [IndexBits-1:0] pick_index();
    int unsigned span;
    span = table_sb.covered;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return IndexBits'($urandom_range(0, span));
      6:                return IndexBits'(span);
      7:                return IndexBits'((span == 0) ? 0 : span - 1);
      default:          return IndexBits'($urandom());
    endcase
  endfunction

  // One random request; the unused field carries junk throughout.
  task automatic random_item();
    if ($urandom_range(0, 99) < 55) begin
      send_item(FUNC_APPEND, pick_line(), IndexBits'($urandom()));
    end else begin
      send_item(FUNC_LOOKUP, FieldLineBits'($urandom()), pick_index());
    end
  endtask

  // Random requests in blocks of forty; roughly one block in four runs with
  // no idling on either side.
  task automatic random_blocks(int blocks);
    for (int b = 0; b < blocks; b++) begin
      steady = ($urandom_range(0, 3) == 0);
      repeat (40) random_item();
    end
    steady = 1'b0;
  endtask

  // Result side: stall a random number of cycles per result, then hold ready
  // until the transfer completes and check it.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
      table_sb.check_answer(rsp_ch.found_line, rsp_ch.status);
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [FieldLineBits-1:0] last_line;

    // Known values on every input from time zero.
    rst                      <= 1'b1;
    steady                   = 1'b0;
    req_ch.valid             <= 1'b0;
    req_ch.func              <= FUNC_APPEND;
    req_ch.line_number       <= '0;
    req_ch.instruction_index <= '0;
    rsp_ch.ready             <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: lookups on an empty table miss, then build a few short runs at the line
    // extremes and two mixed patterns and probe hits, the run boundaries and misses past
    // the last run. Unused fields carry all-zero, all-one or alternating bit patterns.
    send_item(FUNC_LOOKUP, 16'hFFFF, 24'h000000);
    send_item(FUNC_LOOKUP, 16'h0000, 24'hFFFFFF);
    send_item(FUNC_APPEND, 16'h0000, 24'hAAAAAA);
    send_item(FUNC_APPEND, 16'h0000, 24'h555555);
    send_item(FUNC_APPEND, 16'hFFFF, 24'hFFFFFF);
    send_item(FUNC_APPEND, 16'hFFFF, 24'h000000);
    send_item(FUNC_APPEND, 16'h5A5A, 24'h000000);
    send_item(FUNC_APPEND, 16'hA5A5, 24'hFFFFFF);
    send_item(FUNC_APPEND, 16'h0000, 24'h000000);
    send_item(FUNC_LOOKUP, 16'hAAAA, 24'h000000);
    send_item(FUNC_LOOKUP, 16'h5555, 24'h000001);
    send_item(FUNC_LOOKUP, 16'h0000, 24'h000002);
    send_item(FUNC_LOOKUP, 16'hFFFF, 24'h000004);
    send_item(FUNC_LOOKUP, 16'h0000, 24'h000005);
    send_item(FUNC_LOOKUP, 16'h0000, 24'h000006);
    send_item(FUNC_LOOKUP, 16'h0000, 24'h000007);
    send_item(FUNC_LOOKUP, 16'h0000, 24'hFFFFFF);
    send_item(FUNC_LOOKUP, 16'h0000, 24'hAAAAAA);
    send_item(FUNC_LOOKUP, 16'h0000, 24'h555555);

    // Main random phase while the store is still filling.
    random_blocks(16);

    // Probe the end of the covered span: the last two positions and one past.
    send_item(FUNC_LOOKUP, '0, IndexBits'(table_sb.covered - 1));
    send_item(FUNC_LOOKUP, '0, IndexBits'(table_sb.covered - 2));
    send_item(FUNC_LOOKUP, '0, IndexBits'(table_sb.covered));

    // Fill every remaining run slot with fresh lines, with lookups mixed in.
    while (table_sb.runs_used < MaxRuns) begin
      if ($urandom_range(0, 5) == 0) begin
        send_item(FUNC_LOOKUP, FieldLineBits'($urandom()), pick_index());
      end
      last_line = table_sb.run_lines[table_sb.runs_used-1] + 1'b1;
      send_item(FUNC_APPEND, last_line, IndexBits'($urandom()));
    end

    // Full store: a new line is dropped, the last line still lengthens.
    last_line = table_sb.run_lines[MaxRuns-1];
    send_item(FUNC_APPEND, last_line + 1'b1, 24'h000000);
    send_item(FUNC_APPEND, last_line, 24'hFFFFFF);
    send_item(FUNC_LOOKUP, 16'h0000, IndexBits'(table_sb.covered - 1));
    send_item(FUNC_LOOKUP, 16'hFFFF, IndexBits'(table_sb.covered));

    // Random traffic against the full store, long walks included.
    random_blocks(2);

    // Drain: wait for every answer, then linger for any stray result.
    req_ch.valid <= 1'b0;
    while (table_sb.pending.size() != 0) @(posedge clk);
    repeat (MaxRuns + 16) @(posedge clk);

    if (table_sb.faults == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
